/* rtl/core/wcg_pkg.sv */
// ----------------------------------------------------------------------------
// wcg_pkg: shared types and constants of the window coefficient generator
// Window codes, register indexes, fixed-point constants, pipeline payloads.
// ----------------------------------------------------------------------------
package wcg_pkg;

  // Window selection, one code per window shape
  typedef enum logic [2:0] {
    WinRect      = 3'd0,
    WinBartlett  = 3'd1,
    WinHann      = 3'd2,
    WinHamming   = 3'd3,
    WinBlackman  = 3'd4,
    WinBlackHarr = 3'd5,
    WinParzen    = 3'd6,
    WinWelch     = 3'd7
  } wcg_win_e;

  // Register indexes of the configuration port
  localparam int unsigned CfgAddrW        = 1;
  localparam logic [0:0]  CfgWindowType   = 1'b0;
  localparam logic [0:0]  CfgWindowLength = 1'b1;

  localparam logic [2:0]  WinTypeReset    = WinHann;
  localparam logic [16:0] WinLengthReset  = 17'd1024;
  localparam logic [16:0] MaxLength       = 17'd65536;

  localparam int unsigned NumLanes  = 3;
  localparam int unsigned NumSteps  = 32;
  localparam int unsigned NumHorner = 6;
  localparam int unsigned HornerDiv [NumHorner] = '{182, 132, 90, 56, 30, 12};

  // Q2.30 constants (TwoPiQ29 is Q3.29)
  localparam logic [30:0] Q30One    = 31'h4000_0000;
  localparam logic [30:0] Q30Half   = 31'h2000_0000;
  localparam logic [31:0] TwoPiQ29  = 32'd3373259426;
  localparam logic [29:0] WHalf     = 30'd536870912;
  localparam logic [29:0] W042      = 30'd450971566;
  localparam logic [29:0] W008      = 30'd85899346;
  localparam logic [29:0] WBh0      = 30'd385204879;
  localparam logic [29:0] WBh1      = 30'd524297395;
  localparam logic [29:0] WBh2      = 30'd151698245;
  localparam logic [29:0] WBh3      = 30'd12541305;
  localparam logic [29:0] W054      = 30'd579820585;
  localparam logic [29:0] W046      = 30'd493921239;

  // Side data that rides along with a word
  typedef struct packed {
    logic        err;
    logic [30:0] r30;
  } wcg_tag_t;

  // Divider row state: one partial remainder and quotient per lane
  typedef struct packed {
    logic                 err;
    logic [2:0][16:0]     rem;
    logic [2:0][32:0]     quo;
  } wcg_div_t;

endpackage

/* rtl/core/window_coefficient_generator_unit.sv */
// ----------------------------------------------------------------------------
// window_coefficient_generator_unit: FFT window coefficient per sample index
// Streaming lookup-free window generator for eight window shapes.
// ----------------------------------------------------------------------------
// Send a sample index on the slave stream and get the window coefficient on
// the master stream as unsigned Q1.FRAC_BITS (2^FRAC_BITS is 1.0), one word
// per clock while the output is not stalled (a full skid holds the input). The
// pipeline is a row of 32 division cells (one quotient bit each, three lanes
// for the phases k*index/(N-1) or the Bartlett and Parzen ratios), then per
// lane a 24-stage cosine chain (quarter-turn fold, Horner cells, weighting),
// one combine stage and the output register. An index at or above N returns
// zero with the error flag in tuser. Lengths above 65536 act as 65536.
// Write window_type and window_length only while no word is in flight.
// ----------------------------------------------------------------------------
module window_coefficient_generator_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_addr_i,
  input  logic [16:0]                          cfg_wdata_i,
  // input words
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [15:0]                          s_axis_tdata,   // [15:0] sample_index
  // result words
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((FRAC_BITS + 8) / 8) * 8-1:0] m_axis_tdata,   // coefficient, zero fill
  output logic                                 m_axis_tuser    // [0] index_error
);
  import wcg_pkg::*;

  localparam int unsigned CoefW    = FRAC_BITS + 1;
  localparam int unsigned DataW    = ((FRAC_BITS + 8) / 8) * 8;
  localparam int unsigned RndShift = 30 - FRAC_BITS;

  typedef struct packed {
    logic             err;
    logic [CoefW-1:0] coef;
  } res_t;

  // configuration and its derived divisors
  wcg_win_e         win_q;
  logic [16:0]      len_q;
  logic [16:0]      n_eff, d_len, n_inc;
  logic [2:0][16:0] divisor;
  logic [2:0][31:0] low_bits;
  logic [2:0][29:0] weight;
  logic [29:0]      base;

  // front stage
  logic             en;
  logic [18:0]      i1, i2, i3, d1, d2, d3;
  logic [18:0]      r1, r2, r3, bart_m, parz_m;
  logic [2:0][16:0] num;
  wcg_div_t         pre_d;

  // division row
  logic             cv [NumSteps+1];
  wcg_div_t         crow [NumSteps+1];
  wcg_tag_t         lane_tag;

  // cosine lanes and combine
  logic                lane_v;
  wcg_tag_t            lane_tag_o;
  logic signed [32:0]  wm0, wm1, wm2;
  logic                t1_valid_q;
  wcg_tag_t            t1_tag_q;
  logic signed [34:0]  sum_q;
  logic [61:0]         welch_q;
  logic signed [34:0]  win;
  logic [30:0]         wu;
  logic [31:0]         w2;
  logic [CoefW:0]      rnd;
  res_t                res;

  // output register and skid
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= wcg_win_e'(WinTypeReset);
      len_q <= WinLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgWindowType:   win_q <= wcg_win_e'(cfg_wdata_i[2:0]);
        CfgWindowLength: len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective N, N-1 and N+1; lane 0 divides by N+1 for Parzen and Welch
  assign n_eff = (len_q > MaxLength) ? MaxLength : len_q;
  assign d_len = 17'(n_eff - 17'd1);
  assign n_inc = 17'(n_eff + 17'd1);

  always_comb begin
    divisor[0]  = d_len;
    divisor[1]  = d_len;
    divisor[2]  = d_len;
    low_bits[0] = 32'(d_len >> 1);
    low_bits[1] = 32'(d_len >> 1);
    low_bits[2] = 32'(d_len >> 1);
    weight      = '0;
    base        = '0;
    unique case (win_q)
      WinBartlett: begin
        // quotient in Q1.32, rounding offset scaled to match
        low_bits[0] = {13'd0, d_len >> 1, 2'b00};
      end
      WinHann: begin
        weight[0] = WHalf;
        base      = WHalf;
      end
      WinHamming: begin
        weight[0] = W046;
        base      = W054;
      end
      WinBlackman: begin
        weight[0] = WHalf;
        weight[1] = W008;
        base      = W042;
      end
      WinBlackHarr: begin
        weight[0] = WBh1;
        weight[1] = WBh2;
        weight[2] = WBh3;
        base      = WBh0;
      end
      WinParzen, WinWelch: begin
        divisor[0]  = n_inc;
        low_bits[0] = {13'd0, n_inc >> 1, 2'b00};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front stage: reduce the phase numerators mod N-1, take the first
  // quotient bit. Hold everything while the skid holds a word.
  // --------------------------------------------------------------------------
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  always_comb begin
    i1 = {3'd0, s_axis_tdata};
    i2 = i1 << 1;
    i3 = 19'(i1 + i2);
    d1 = {2'd0, d_len};
    d2 = d1 << 1;
    d3 = 19'(d1 + d2);
    r1 = (i1 == d1) ? '0 : i1;
    r2 = (i2 >= d2) ? 19'(i2 - d2) : (i2 >= d1) ? 19'(i2 - d1) : i2;
    r3 = (i3 >= d3) ? 19'(i3 - d3) : (i3 >= d2) ? 19'(i3 - d2)
       : (i3 >= d1) ? 19'(i3 - d1) : i3;
    bart_m = (i2 > d1) ? ((d2 > i2) ? 19'(d2 - i2) : '0) : i2;
    parz_m = (i2 >= d1) ? 19'(i2 - d1) : 19'(d1 - i2);

    num[1] = r2[16:0];
    num[2] = r3[16:0];
    if (win_q == WinBartlett) begin
      num[0] = bart_m[16:0];
    end else if (win_q == WinParzen || win_q == WinWelch) begin
      num[0] = parz_m[16:0];
    end else begin
      num[0] = r1[16:0];
    end

    pre_d.err = {1'b0, s_axis_tdata} >= n_eff;
    for (int l = 0; l < NumLanes; l++) begin
      pre_d.quo[l] = {32'd0, num[l] >= divisor[l]};
      pre_d.rem[l] = (num[l] >= divisor[l]) ? 17'(num[l] - divisor[l]) : num[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crow[0] <= pre_d;
    end
  end

  // --------------------------------------------------------------------------
  // Division row: one quotient bit per cell, dividend low bits MSB first
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < NumSteps; g++) begin : g_div
    wcg_div_cell #(
      .BIT_POS (NumSteps - 1 - g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (divisor),
      .low_i     (low_bits),
      .valid_i   (cv[g]),
      .row_i     (crow[g]),
      .valid_o   (cv[g+1]),
      .row_o     (crow[g+1])
    );
  end

  // lane 0 also carries the Bartlett or Parzen ratio in Q30
  assign lane_tag.err = crow[NumSteps].err;
  assign lane_tag.r30 = crow[NumSteps].quo[0][32:2];

  wcg_cos_lane u_lane0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (cv[NumSteps]),
    .tag_i    (lane_tag),
    .phase_i  (crow[NumSteps].quo[0][31:0]),
    .weight_i (weight[0]),
    .valid_o  (lane_v),
    .tag_o    (lane_tag_o),
    .wm_o     (wm0)
  );

  wcg_cos_lane u_lane1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (cv[NumSteps]),
    .tag_i    (lane_tag),
    .phase_i  (crow[NumSteps].quo[1][31:0]),
    .weight_i (weight[1]),
    .valid_o  (),
    .tag_o    (),
    .wm_o     (wm1)
  );

  wcg_cos_lane u_lane2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (cv[NumSteps]),
    .tag_i    (lane_tag),
    .phase_i  (crow[NumSteps].quo[2][31:0]),
    .weight_i (weight[2]),
    .valid_o  (),
    .tag_o    (),
    .wm_o     (wm2)
  );

  // --------------------------------------------------------------------------
  // Combine stage: cosine sum and Welch square
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else if (en) begin
      t1_valid_q <= lane_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q    <= signed'({5'd0, base}) - 35'(wm0) + 35'(wm1) - 35'(wm2);
      welch_q  <= 62'(lane_tag_o.r30) * 62'(lane_tag_o.r30) + 62'(Q30Half);
      t1_tag_q <= lane_tag_o;
    end
  end

  // select the window, clamp to [0, 1.0], round half up to FRAC_BITS
  always_comb begin
    win = signed'(35'(Q30One));
    unique case (win_q)
      WinRect:     win = signed'(35'(Q30One));
      WinBartlett: win = signed'({4'd0, t1_tag_q.r30});
      WinParzen:   win = signed'(35'(Q30One)) - signed'({4'd0, t1_tag_q.r30});
      WinWelch:    win = signed'(35'(Q30One)) - signed'({3'd0, welch_q[61:30]});
      default:     win = sum_q;
    endcase
    if (n_eff < 17'd2) begin
      win = signed'(35'(Q30One));
    end

    if (win[34]) begin
      wu = '0;
    end else if (win > signed'(35'(Q30One))) begin
      wu = Q30One;
    end else begin
      wu = win[30:0];
    end

    w2       = {wu, 1'b0} >> RndShift;
    rnd      = w2[CoefW:0] + (CoefW+1)'(1);
    res.err  = t1_tag_q.err;
    res.coef = t1_tag_q.err ? '0 : rnd[CoefW:1];
  end

  // --------------------------------------------------------------------------
  // Output register with skid: a stalled word parks in the skid and the
  // pipeline holds until it drains
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (t1_valid_q) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (t1_valid_q) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'(out_q.coef);
  assign m_axis_tuser  = out_q.err;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid filled without a stalled output word");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (out_q.coef == '0))
    else $error("index error word carries a nonzero coefficient");

  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.coef <= (CoefW)'(1) << FRAC_BITS))
    else $error("coefficient above 1.0");

endmodule

/* rtl/core/wcg_div_cell.sv */
// ----------------------------------------------------------------------------
// wcg_div_cell: one restoring division step for all three lanes
// Shift one dividend bit into each partial remainder, subtract when it fits.
// ----------------------------------------------------------------------------
module wcg_div_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [2:0][16:0]         divisor_i,
  input  logic [2:0][31:0]         low_i,
  input  logic                     valid_i,
  input  wcg_pkg::wcg_div_t        row_i,
  output logic                     valid_o,
  output wcg_pkg::wcg_div_t        row_o
);
  import wcg_pkg::*;

  wcg_div_t         row_d, row_q;
  logic             valid_q;
  logic [2:0][17:0] part;
  logic [2:0]       fits;

  always_comb begin
    row_d = row_i;
    for (int l = 0; l < NumLanes; l++) begin
      part[l] = {row_i.rem[l], low_i[l][BIT_POS]};
      fits[l] = part[l] >= {1'b0, divisor_i[l]};
      row_d.rem[l] = fits[l] ? 17'(part[l] - {1'b0, divisor_i[l]}) : part[l][16:0];
      row_d.quo[l] = {row_i.quo[l][31:0], fits[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  assign valid_o = valid_q;
  assign row_o   = row_q;

endmodule

/* rtl/core/wcg_horner_cell.sv */
// ----------------------------------------------------------------------------
// wcg_horner_cell: one Horner step of the cosine series
// h_next = 1 - round(floor(x2*h/K)), with the divide by K done as a
// reciprocal multiply that is exact for 32-bit operands.
// ----------------------------------------------------------------------------
module wcg_horner_cell #(
  parameter int unsigned K_DIV = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        x2_i,
  input  logic [30:0]        h_i,
  input  logic               neg_i,
  input  wcg_pkg::wcg_tag_t  tag_i,
  output logic               valid_o,
  output logic [31:0]        x2_o,
  output logic [30:0]        h_o,
  output logic               neg_o,
  output wcg_pkg::wcg_tag_t  tag_o
);
  import wcg_pkg::*;

  localparam int unsigned ShiftS = 32 + $clog2(K_DIV);
  localparam logic [32:0] Magic  =
    33'(((65'd1 << ShiftS) + 65'(K_DIV) - 65'd1) / 65'(K_DIV));

  logic [2:0]  vld_q;
  logic [31:0] x2_a_q, x2_b_q, x2_c_q;
  logic        neg_a_q, neg_b_q, neg_c_q;
  wcg_tag_t    tag_a_q, tag_b_q, tag_c_q;
  logic [62:0] prod_q;
  logic [64:0] recip_q;
  logic [32:0] term;
  logic [30:0] h_q;

  assign term = 33'(recip_q >> ShiftS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // product plus the rounding bias scaled by K
      prod_q  <= 63'(x2_i) * 63'(h_i) + (63'(K_DIV) << 29);
      x2_a_q  <= x2_i;
      neg_a_q <= neg_i;
      tag_a_q <= tag_i;
      // divide the rounded Q30 value by K
      recip_q <= 65'(prod_q[61:30]) * 65'(Magic);
      x2_b_q  <= x2_a_q;
      neg_b_q <= neg_a_q;
      tag_b_q <= tag_a_q;
      // saturate one minus the term at zero
      h_q     <= (term >= 33'(Q30One)) ? '0 : 31'(33'(Q30One) - term);
      x2_c_q  <= x2_b_q;
      neg_c_q <= neg_b_q;
      tag_c_q <= tag_b_q;
    end
  end

  assign valid_o = vld_q[2];
  assign x2_o    = x2_c_q;
  assign h_o     = h_q;
  assign neg_o   = neg_c_q;
  assign tag_o   = tag_c_q;

endmodule

/* rtl/core/wcg_cos_lane.sv */
// ----------------------------------------------------------------------------
// wcg_cos_lane: phase to weighted cosine
// Fold the phase into a quarter turn, run the Horner chain, then scale the
// cosine by the lane weight with rounding half away from zero.
// ----------------------------------------------------------------------------
module wcg_cos_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  wcg_pkg::wcg_tag_t   tag_i,
  input  logic [31:0]         phase_i,
  input  logic [29:0]         weight_i,
  output logic                valid_o,
  output wcg_pkg::wcg_tag_t   tag_o,
  output logic signed [32:0]  wm_o
);
  import wcg_pkg::*;

  logic [30:0]        u;
  logic               neg_d;
  logic [5:0]         vld_q;
  logic               neg0_q, neg1_q, neg2_q, sgn3_q, sgn4_q;
  wcg_tag_t           tag0_q, tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic [62:0]        th_q;
  logic [61:0]        sq_q;
  logic [62:0]        fp_q;
  logic [31:0]        mag3_q;
  logic [61:0]        wp_q;
  logic signed [32:0] wm_q;
  logic [31:0]        fterm;
  logic signed [32:0] cq;
  logic [32:0]        wv;

  logic               hv   [NumHorner+1];
  logic [31:0]        hx2  [NumHorner+1];
  logic [30:0]        hh   [NumHorner+1];
  logic               hneg [NumHorner+1];
  wcg_tag_t           htag [NumHorner+1];

  // quadrant fold: odd quadrants mirror, middle two negate
  assign u     = phase_i[30] ? 31'(Q30One - {1'b0, phase_i[29:0]}) : {1'b0, phase_i[29:0]};
  assign neg_d = phase_i[31] ^ phase_i[30];

  assign hv[0]   = vld_q[1];
  assign hx2[0]  = sq_q[61:30];
  assign hh[0]   = Q30One;
  assign hneg[0] = neg1_q;
  assign htag[0] = tag1_q;

  for (genvar g = 0; g < NumHorner; g++) begin : g_horner
    wcg_horner_cell #(
      .K_DIV (HornerDiv[g])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (hv[g]),
      .x2_i    (hx2[g]),
      .h_i     (hh[g]),
      .neg_i   (hneg[g]),
      .tag_i   (htag[g]),
      .valid_o (hv[g+1]),
      .x2_o    (hx2[g+1]),
      .h_o     (hh[g+1]),
      .neg_o   (hneg[g+1]),
      .tag_o   (htag[g+1])
    );
  end

  assign fterm = fp_q[62:31];
  assign cq    = signed'({2'b00, Q30One}) - signed'({1'b0, fterm});
  assign wv    = {1'b0, wp_q[61:30]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      vld_q[1] <= vld_q[0];
      vld_q[2] <= hv[NumHorner];
      vld_q[3] <= vld_q[2];
      vld_q[4] <= vld_q[3];
      vld_q[5] <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      th_q   <= 63'(u) * 63'(TwoPiQ29) + 63'(Q30One);
      neg0_q <= neg_d;
      tag0_q <= tag_i;
      sq_q   <= 62'(th_q[61:31]) * 62'(th_q[61:31]) + 62'(Q30Half);
      neg1_q <= neg0_q;
      tag1_q <= tag0_q;
      // last Horner step divides by two
      fp_q   <= 63'(hx2[NumHorner]) * 63'(hh[NumHorner]) + 63'(Q30One);
      neg2_q <= hneg[NumHorner];
      tag2_q <= htag[NumHorner];
      mag3_q <= cq[32] ? 32'(-cq) : 32'(cq);
      sgn3_q <= neg2_q ^ cq[32];
      tag3_q <= tag2_q;
      wp_q   <= 62'(weight_i) * 62'(mag3_q) + 62'(Q30Half);
      sgn4_q <= sgn3_q;
      tag4_q <= tag3_q;
      wm_q   <= sgn4_q ? -signed'(wv) : signed'(wv);
      tag5_q <= tag4_q;
    end
  end

  assign valid_o = vld_q[5];
  assign tag_o   = tag5_q;
  assign wm_o    = wm_q;

endmodule
